@@ rtl/core/byte_string_hash_token_core_assert.svh @@
// ----------------------------------------------------------------------------
// Byte string hash token core assertion macros
// Shared concurrent assertion forms used by the hash core.
// ----------------------------------------------------------------------------
`ifndef BYTE_STRING_HASH_TOKEN_CORE_ASSERT_SVH
`define BYTE_STRING_HASH_TOKEN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hash core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hash core assertion failed");

`endif

@@ rtl/core/bsht_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte string hash token package
// Constants of the 32-bit string hash and the stream payload widths.
// ----------------------------------------------------------------------------
package bsht_pkg;

	localparam logic [31:0] SEED       = 32'hbc9f1d34;
	localparam logic [31:0] MULT       = 32'hc6a4a793;
	localparam logic [31:0] MAX_LENGTH = 32'd65535;
	localparam int          WORD_SHIFT = 16;
	localparam int          TAIL_SHIFT = 24;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int HASH_W  = 32;
	localparam int TOKEN_W = 33;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 72;

endpackage

@@ rtl/core/byte_string_hash_token_core.sv @@
// Usage: strings enter on the slave stream one byte per beat. The first beat
// of a string carries the string length in s_tdata[23:8]; later beats ignore
// that field. A length of zero ends the string on that same beat and gives
// the seed as hash with token 0. One result beat leaves on the master stream
// per string: the 32-bit hash and the 33-bit token (hash plus one).
// Timing: all arithmetic goes through one shared 32x32 constant multiplier
// under a small sequencer, so s_tready is high only while the sequencer is
// idle. Each byte goes through the byte state; a byte that completes a 4-byte
// word then goes through the multiply and xor-shift states (add, multiply,
// xor-shift), the first byte of a string first takes a seed multiply, and
// the last byte adds any tail mix and the output register load in finish.
// Stall: the result sits in an output register; the next string's bytes are
// accepted while it waits, and the sequencer holds only when a new result
// is ready and the register is still full.
// Reset: arst_n clears the sequencer and the output valid; the first beat
// after reset starts a new string.
// ----------------------------------------------------------------------------
// Byte string hash token core
// Hashes length-prefixed byte strings into 32-bit hashes and token ids.
// ----------------------------------------------------------------------------
`include "byte_string_hash_token_core_assert.svh"

module byte_string_hash_token_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], string_length[23:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // hash_value[31:0], token_id[64:32], zero[71:65]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_BYTE,
		ST_TAIL,
		ST_MUL,
		ST_XOR,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [bsht_pkg::BYTE_W-1:0]     byte_q;
	logic [bsht_pkg::HASH_W-1:0]     hash_q;
	logic [bsht_pkg::HASH_W-1:0]     mul_a_q;
	logic [23:0]                     pend_q;
	logic [1:0]                      pcnt_q;
	logic [bsht_pkg::LEN_W-1:0]      left_q;
	logic                            start_q;
	logic                            last_q;
	logic                            tail_q;
	logic                            empty_q;
	logic                            out_valid_q;
	logic [bsht_pkg::HASH_W-1:0]     out_hash_q;
	logic [bsht_pkg::TOKEN_W-1:0]    out_token_q;

	logic [bsht_pkg::BYTE_W-1:0]     in_byte;
	logic [bsht_pkg::LEN_W-1:0]      in_len;
	logic [bsht_pkg::LEN_W-1:0]      len_clamped;
	logic [bsht_pkg::HASH_W-1:0]     prod;
	logic [bsht_pkg::HASH_W-1:0]     add_b;
	logic [bsht_pkg::HASH_W-1:0]     sum;
	logic [bsht_pkg::HASH_W-1:0]     xor_shifted;
	logic                            in_fire;
	logic                            out_free;

	assign in_byte  = s_tdata[7:0];
	assign in_len   = s_tdata[23:8];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign len_clamped = ({16'd0, in_len} > bsht_pkg::MAX_LENGTH) ?
		bsht_pkg::MAX_LENGTH[bsht_pkg::LEN_W-1:0] : in_len;

	// Shared unit: one constant multiply, one adder and the xor-shift.
	assign prod  = mul_a_q * bsht_pkg::MULT;
	assign add_b = (state_q == ST_TAIL) ? {8'd0, pend_q} : {byte_q, pend_q};
	assign sum   = hash_q + add_b;
	assign xor_shifted = tail_q ? (hash_q ^ (hash_q >> bsht_pkg::TAIL_SHIFT))
		: (hash_q ^ (hash_q >> bsht_pkg::WORD_SHIFT));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_token_q, out_hash_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b1;
			out_valid_q <= 1'b0;
			pcnt_q      <= 2'd0;
			pend_q      <= 24'd0;
			left_q      <= '0;
			last_q      <= 1'b0;
			tail_q      <= 1'b0;
			empty_q     <= 1'b0;
			hash_q      <= '0;
			mul_a_q     <= '0;
			byte_q      <= '0;
			out_hash_q  <= '0;
			out_token_q <= '0;
		end else begin
			// In the finish state the output register is reloaded below instead.
			if (out_valid_q && m_tready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						byte_q <= in_byte;
						if (start_q) begin
							if (len_clamped == '0) begin
								hash_q  <= bsht_pkg::SEED;
								empty_q <= 1'b1;
								state_q <= ST_FINISH;
							end else begin
								mul_a_q <= {16'd0, len_clamped};
								left_q  <= len_clamped;
								pend_q  <= 24'd0;
								pcnt_q  <= 2'd0;
								start_q <= 1'b0;
								empty_q <= 1'b0;
								state_q <= ST_SEED;
							end
						end else begin
							state_q <= ST_BYTE;
						end
					end
				end
				ST_SEED: begin
					hash_q  <= bsht_pkg::SEED ^ prod;
					state_q <= ST_BYTE;
				end
				ST_BYTE: begin
					left_q <= left_q - 1'b1;
					last_q <= (left_q == 16'd1);
					if (pcnt_q == 2'd3) begin
						mul_a_q <= sum;
						tail_q  <= 1'b0;
						pend_q  <= 24'd0;
						pcnt_q  <= 2'd0;
						state_q <= ST_MUL;
					end else begin
						case (pcnt_q)
							2'd0:    pend_q[7:0]   <= byte_q;
							2'd1:    pend_q[15:8]  <= byte_q;
							default: pend_q[23:16] <= byte_q;
						endcase
						pcnt_q  <= pcnt_q + 2'd1;
						state_q <= (left_q == 16'd1) ? ST_TAIL : ST_IDLE;
					end
				end
				ST_TAIL: begin
					mul_a_q <= sum;
					tail_q  <= 1'b1;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					hash_q  <= prod;
					state_q <= ST_XOR;
				end
				ST_XOR: begin
					hash_q  <= xor_shifted;
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_hash_q  <= hash_q;
						out_token_q <= empty_q ? '0 : ({1'b0, hash_q} + 33'd1);
						pend_q      <= 24'd0;
						pcnt_q      <= 2'd0;
						last_q      <= 1'b0;
						start_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A zero token comes only from an empty string, whose hash is the seed.
	`BSHT_ASSERT_NOW(a_zero_token_seed, clk, arst_n,
		m_tvalid && (m_tdata[64:32] == 33'd0), m_tdata[31:0] == bsht_pkg::SEED)
	`BSHT_ASSERT_NOW(a_token_is_hash_plus_one, clk, arst_n,
		m_tvalid && (m_tdata[64:32] != 33'd0),
		m_tdata[64:32] == ({1'b0, m_tdata[31:0]} + 33'd1))
	`BSHT_ASSERT_NEXT(a_mul_then_xor, clk, arst_n, state_q == ST_MUL, state_q == ST_XOR)
	`BSHT_ASSERT_NOW(a_finish_all_bytes, clk, arst_n,
		(state_q == ST_FINISH) && !empty_q, left_q == '0)

endmodule

@@ test/byte_string_hash_token_core_tb.sv @@
// ----------------------------------------------------------------------------
// Byte string hash token core testbench
// Streams length-prefixed byte strings into the core, predicts each string's
// hash and token on the side, and checks every result beat against it.
// Both stream sides idle at random, and one long output stall backs the core
// up.
// ----------------------------------------------------------------------------
module byte_string_hash_token_core_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 600;
	localparam int SHORT_BEATS    = 1350;
	localparam int LONGEST        = 200;

	typedef struct packed {
		logic        drain;
		logic [3:0]  gap;
		logic [15:0] length;
		logic [7:0]  data;
	} beat_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [32:0] token;
	} digest_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;     // data_byte[7:0], string_length[23:8]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // hash_value[31:0], token_id[64:32], zero[71:65]

	beat_t   pending_beats[$];
	digest_t expected_digests[$];
	beat_t   next_beat;

	// Shadow copy of the core's hashing state.
	logic [31:0] run_hash   = '0;
	logic [23:0] tail_bytes = '0;
	logic [1:0]  tail_count = '0;
	logic [15:0] bytes_left = '0;
	logic        at_start   = 1'b1;

	int unsigned gap_left, stall_left, stall_next, hold_left, idle_cycles;
	bit          hold_done;
	int unsigned beats_taken, strings_checked, empties_checked, errors;

	byte_string_hash_token_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] stir(input logic [31:0] h, input logic [31:0] w,
			input int sh);
		logic [31:0] t;
		t = (h + w) * bsht_pkg::MULT;
		return t ^ (t >> sh);
	endfunction

	// Appends one predicted result to the tail of the expected queue.
	task automatic expect_digest(input logic [31:0] hash, input logic [32:0] token);
		digest_t d;
		d.hash  = hash;
		d.token = token;
		expected_digests = {expected_digests, d};
	endtask

	// Advances the shadow state by one accepted beat and queues a digest when
	// the beat closes a string.
	task automatic hash_beat(input logic [7:0] data, input logic [15:0] length);
		logic [31:0] len_eff;
		if (at_start) begin
			len_eff = (32'(length) > bsht_pkg::MAX_LENGTH) ? bsht_pkg::MAX_LENGTH
				: 32'(length);
			if (len_eff == 0) begin
				expect_digest(bsht_pkg::SEED, 33'd0);
				return;
			end
			run_hash   = bsht_pkg::SEED ^ (len_eff * bsht_pkg::MULT);
			tail_bytes = '0;
			tail_count = '0;
			bytes_left = 16'(len_eff);
			at_start   = 1'b0;
		end
		if (tail_count == 2'd3) begin
			run_hash   = stir(run_hash, {data, tail_bytes}, bsht_pkg::WORD_SHIFT);
			tail_bytes = '0;
			tail_count = '0;
		end else begin
			tail_bytes[8*tail_count +: 8] = data;
			tail_count++;
		end
		bytes_left--;
		if (bytes_left == 0) begin
			if (tail_count != 0)
				run_hash = stir(run_hash, {8'd0, tail_bytes}, bsht_pkg::TAIL_SHIFT);
			expect_digest(run_hash, {1'b0, run_hash} + 33'd1);
			tail_bytes = '0;
			tail_count = '0;
			at_start   = 1'b1;
		end
	endtask

	// A negative fill gives random bytes. Beats after the first carry a random
	// length field, which the core must ignore.
	task automatic queue_string(input int unsigned len, input int fill,
			input int unsigned gap_max, input bit drain);
		beat_t b;
		int unsigned i;
		i = 0;
		do begin
			b.drain  = drain && (i == 0);
			b.gap    = 4'($urandom_range(0, gap_max));
			b.length = (i == 0) ? 16'(len) : 16'($urandom);
			b.data   = (fill < 0) ? 8'($urandom) : 8'(fill);
			pending_beats = {pending_beats, b};
			i++;
		end while (i < len);
	endtask

	task automatic check_digest(input logic [71:0] word);
		digest_t want;
		if (expected_digests.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: hash %h token %h", $time, word[31:0],
				word[64:32]);
			return;
		end
		want = expected_digests.pop_front();
		if (word[31:0] !== want.hash) begin
			errors++;
			$display("%0t: hash_value expected %h got %h", $time, want.hash, word[31:0]);
		end
		if (word[64:32] !== want.token) begin
			errors++;
			$display("%0t: token_id expected %h got %h", $time, want.token, word[64:32]);
		end
		if (word[71:65] !== '0) begin
			errors++;
			$display("%0t: pad bits expected 0 got %h", $time, word[71:65]);
		end
		if (want.token == 0)
			empties_checked++;
		strings_checked++;
	endtask

	// Sender. A beat flagged drain is held back until every result is in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid    <= 1'b0;
			s_tdata     <= '0;
			gap_left    <= 0;
			beats_taken <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				hash_beat(s_tdata[7:0], s_tdata[23:8]);
				beats_taken <= beats_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_beats.size() != 0 &&
						!(pending_beats[0].drain && expected_digests.size() != 0)) begin
					next_beat = pending_beats.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= {next_beat.length, next_beat.data};
					gap_left  <= (pending_beats.size() != 0) ?
						32'(pending_beats[0].gap) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Every third run of fifty results goes without stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_next = stall_left;
			if (m_tvalid && m_tready) begin
				check_digest(m_tdata);
				stall_next = ((strings_checked / 50) % 3 == 0) ? 0 : $urandom_range(0, 8);
			end else if (stall_next != 0) begin
				stall_next--;
			end
			stall_left <= stall_next;
			m_tready   <= (stall_next == 0) && (hold_left == 0);
		end
	end

	// One long output stall partway through the short strings.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned roll, len, gap_max;
		bit first;

		// Empty strings, single bytes at both extremes, each tail size and a
		// whole word, back-to-back empties.
		queue_string(0, 255, 0, 1'b0);
		queue_string(1, 0, 3, 1'b0);
		queue_string(1, 255, 3, 1'b0);
		queue_string(3, 255, 0, 1'b0);
		queue_string(4, 255, 0, 1'b0);
		queue_string(5, -1, 8, 1'b0);
		queue_string(0, 0, 0, 1'b0);
		queue_string(0, -1, 0, 1'b0);
		queue_string(2, -1, 8, 1'b0);

		first = 1'b1;
		while (pending_beats.size() < SHORT_BEATS) begin
			roll = $urandom_range(0, 15);
			if (roll < 2)
				len = 0;
			else if (roll == 2)
				len = $urandom_range(13, 80);
			else
				len = $urandom_range(1, 12);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			queue_string(len, -1, gap_max, first || ($urandom_range(0, 39) == 0));
			first = 1'b0;
		end
		// A long string at the end, sent back to back.
		queue_string(LONGEST, -1, 0, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_digests.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Hashed %0d beats into %0d strings, %0d of them empty, the longest %0d bytes;",
			beats_taken, strings_checked, empties_checked, LONGEST);
		$display("the output was held off once for %0d cycles with input still offered.",
			HOLD_CYCLES);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
